/* rtl/core/sar_broadside_phase_reference_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the broadside phase reference checkers.
// Both expect i_clk and i_rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SAR_BROADSIDE_PHASE_REFERENCE_ASSERT_SVH
`define SAR_BROADSIDE_PHASE_REFERENCE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbpr assertion failed");

// consequent must hold in the cycle after the antecedent
`define SBPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbpr assertion failed");

`endif

/* rtl/core/sbpr_pkg.sv */
// ----------------------------------------------------------------------------
// sbpr_pkg
// Shared types and constants of the broadside phase reference block.
// ----------------------------------------------------------------------------
package sbpr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_NUM_ROWS      = 3'd1,
        REG_NUM_COLS      = 3'd2,
        REG_RANGE_SPACING = 3'd3,
        REG_ALONG_STEP    = 3'd4,
        REG_TWO_OVER_WL   = 3'd5
    } t_reg_idx;

    // register field widths
    localparam int DIM_CFG_W = 13;
    localparam int DIST_W    = 24;
    localparam int TOW_W     = 32;

    // register reset values
    localparam logic [DIM_CFG_W-1:0] RST_NUM_ROWS  = 13'd1;
    localparam logic [DIM_CFG_W-1:0] RST_NUM_COLS  = 13'd1;
    localparam logic [DIST_W-1:0]    RST_SPACING   = 24'd65536;
    localparam logic [DIST_W-1:0]    RST_STEP      = 24'd65536;
    localparam logic [TOW_W-1:0]     RST_TOW       = 32'd4194304;

    // phase word: 2^-16 turn, saturating
    localparam int                  PHASE_W   = 44;
    localparam logic [PHASE_W-1:0]  PHASE_MAX = 44'hFFF_FFFF_FFFF;
    localparam int                  PH_SHIFT  = 23;
    localparam int                  FRAC_W    = 16;

    // multiply-accumulate chunk
    localparam int CHUNK_W = 16;

    // rotator
    localparam int                  ANGLE_W   = 32;
    localparam int                  ATAN_N    = 32;
    localparam int                  CX_TOP    = 37;   // sample scale exponent plus width
    localparam int                  CX_W      = 40;
    localparam int                  Z_W       = 34;
    localparam int                  GAIN_K_W  = 24;
    localparam logic [GAIN_K_W-1:0] GAIN_K    = 24'd10188014;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // controller states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SEED  = 11'b000_0000_0010,
        S_MULX  = 11'b000_0000_0100,
        S_MULR  = 11'b000_0000_1000,
        S_SUM   = 11'b000_0001_0000,
        S_ROOT  = 11'b000_0010_0000,
        S_PHMUL = 11'b000_0100_0000,
        S_PHFIN = 11'b000_1000_0000,
        S_ROT   = 11'b001_0000_0000,
        S_GAIN  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic seed;
        logic mac_step;
        logic mac_to_r;
        logic sum;
        logic root_step;
        logic root_last;
        logic ph_fin;
        logic rot_step;
        logic gain;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/sbpr_ctrl.sv */
// ----------------------------------------------------------------------------
// sbpr_ctrl
// Sequencer: in reference mode, seed, squares, root, phase, rotation per item.
// ----------------------------------------------------------------------------
module sbpr_ctrl #(
    parameter int NX     = 3,
    parameter int S_W    = 38,
    parameter int STAGES = 16,
    parameter int STEP_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  sbpr_pkg::t_stat    i_stat,
    output sbpr_pkg::t_cmd     o_cmd,
    output logic [STEP_W-1:0]  o_step
);
    import sbpr_pkg::*;

    localparam logic [STEP_W-1:0] NX_LAST   = STEP_W'(NX - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(S_W - 1);
    localparam logic [STEP_W-1:0] ROT_LAST  = STEP_W'(STAGES - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_cmd              cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = i_mode ? S_SEED : S_DONE;
                end
            end
            S_SEED: begin
                cmd.seed = 1'b1;
                n_state  = S_MULX;
            end
            S_MULX: begin
                cmd.mac_step = 1'b1;
                if (r_step == NX_LAST) begin
                    cmd.mac_to_r = 1'b1;
                    n_state      = S_MULR;
                    n_step       = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MULR: begin
                cmd.mac_step = 1'b1;
                if (r_step == NX_LAST) begin
                    n_state = S_SUM;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (r_step == ROOT_LAST) begin
                    cmd.root_last = 1'b1;
                    n_state       = S_PHMUL;
                    n_step        = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PHMUL: begin
                cmd.mac_step = 1'b1;
                if (r_step == NX_LAST) begin
                    n_state = S_PHFIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PHFIN: begin
                cmd.ph_fin = 1'b1;
                n_state    = S_ROT;
            end
            S_ROT: begin
                cmd.rot_step = 1'b1;
                if (r_step == ROT_LAST) begin
                    n_state = S_GAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_GAIN: begin
                cmd.gain = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;
    assign o_step     = r_step;

endmodule

/* rtl/core/sbpr_dp.sv */
// ----------------------------------------------------------------------------
// sbpr_dp
// Datapath: pixel counters, chunked multiply-accumulate, bit-serial square
// root, phase min/max tracking, iterative rotator and output register.
// ----------------------------------------------------------------------------
module sbpr_dp #(
    parameter int MAX_DIM      = 4096,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CW           = 12,
    parameter int DW           = 13,
    parameter int X_W          = 37,
    parameter int S_W          = 38,
    parameter int NX           = 3,
    parameter int ACC_W        = 75,
    parameter int STEP_W       = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sbpr_pkg::t_cmd                       i_cmd,
    output sbpr_pkg::t_stat                      o_stat,
    input  logic [STEP_W-1:0]                    i_step,
    // configuration
    input  logic                                 i_mode,
    input  logic [sbpr_pkg::DIM_CFG_W-1:0]       i_num_rows,
    input  logic [sbpr_pkg::DIM_CFG_W-1:0]       i_num_cols,
    input  logic [sbpr_pkg::DIST_W-1:0]          i_range_spacing,
    input  logic [sbpr_pkg::DIST_W-1:0]          i_along_step,
    input  logic [sbpr_pkg::TOW_W-1:0]           i_tow,
    // samples
    input  logic [SAMPLE_WIDTH-1:0]              i_sample_re,
    input  logic [SAMPLE_WIDTH-1:0]              i_sample_im,
    // results
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]              o_out_re,
    output logic [SAMPLE_WIDTH-1:0]              o_out_im,
    output logic                                 o_last_pixel,
    output logic                                 o_applied,
    output logic [sbpr_pkg::PHASE_W-1:0]         o_min_phase,
    output logic [sbpr_pkg::PHASE_W-1:0]         o_max_phase
);
    import sbpr_pkg::*;

    localparam int AD_W  = CW + 1;
    localparam int BW    = NX * CHUNK_W;
    localparam int MP_W  = S_W + CHUNK_W;
    localparam int R_W   = S_W + 2;
    localparam int RAD_W = 2 * S_W;
    localparam int P_W   = (ACC_W + 1 > PHASE_W + PH_SHIFT + 1) ? ACC_W + 1
                                                               : PHASE_W + PH_SHIFT + 1;
    localparam int PH_W  = P_W - PH_SHIFT;
    localparam int G     = CX_TOP - SAMPLE_WIDTH;
    localparam int GP_W  = CX_W + GAIN_K_W + 1;

    localparam logic [P_W-1:0] PH_RND = {{(P_W-PH_SHIFT){1'b0}}, 1'b1, {(PH_SHIFT-1){1'b0}}};
    localparam logic signed [GP_W-1:0] G_RND =
        {{(GP_W-G-24){1'b0}}, 1'b1, {(G+23){1'b0}}};
    localparam logic signed [GP_W-1:0] SAT_HI =
        {{(GP_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [GP_W-1:0] SAT_LO =
        {{(GP_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [GAIN_K_W:0] GAIN_K_S = {1'b0, GAIN_K};

    // round the gain-corrected value and clip to the sample range
    function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [GP_W-1:0] v);
        logic signed [GP_W-1:0] s;
        logic [SAMPLE_WIDTH-1:0] q;
        s = (v + G_RND) >>> (G + 24);
        if (s > SAT_HI) begin
            q = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (s < SAT_LO) begin
            q = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            q = s[SAMPLE_WIDTH-1:0];
        end
        return q;
    endfunction

    // item registers
    logic [CW-1:0]           r_row, r_col;
    logic [CW-1:0]           r_prow, r_pcol;   // position of the item in work
    logic [DW-1:0]           r_rows;
    logic                    r_last, r_mode;
    logic [SAMPLE_WIDTH-1:0] r_re, r_im;
    // multiply-accumulate and root
    logic [X_W-1:0]          r_r2;
    logic [S_W-1:0]          r_ma;
    logic [BW-1:0]           r_mb;
    logic [ACC_W-1:0]        r_acc, r_sqx;
    logic [RAD_W-1:0]        r_rad;
    logic [R_W-1:0]          r_rem;
    logic [S_W-1:0]          r_root;
    // phase tracking
    logic [PHASE_W-1:0]      r_min, r_max;
    logic                    r_first;
    // rotator
    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic signed [Z_W-1:0]   r_cz;
    logic signed [GP_W-1:0]  r_gx, r_gy;
    // output stage
    logic                    r_ov;
    logic [SAMPLE_WIDTH-1:0] r_o_re, r_o_im;
    logic                    r_o_last, r_o_app;
    logic [PHASE_W-1:0]      r_o_min, r_o_max;

    // ---- pixel position at capture
    logic [DW-1:0]   rows_c, cols_c;
    logic            last_row, last_col;

    always_comb begin
        rows_c = DW'(i_num_rows);
        if (i_num_rows == '0) begin
            rows_c = DW'(1);
        end else if (DW'(i_num_rows) > DW'(MAX_DIM)) begin
            rows_c = DW'(MAX_DIM);
        end
        cols_c = DW'(i_num_cols);
        if (i_num_cols == '0) begin
            cols_c = DW'(1);
        end else if (DW'(i_num_cols) > DW'(MAX_DIM)) begin
            cols_c = DW'(MAX_DIM);
        end
        last_row = ({1'b0, DW'(r_row)} + (DW+1)'(1)) >= {1'b0, rows_c};
        last_col = ({1'b0, DW'(r_col)} + (DW+1)'(1)) >= {1'b0, cols_c};
    end

    // ---- seed: along-track and range offsets in 2^-17 m
    logic [DW-1:0]         rows_m1;
    logic signed [AD_W:0]  diff;
    logic [AD_W-1:0]       ad;
    logic [X_W-1:0]        x2, r2p, r2;

    always_comb begin
        rows_m1 = r_rows - DW'(1);
        diff    = $signed({1'b0, r_prow, 1'b0}) - $signed({1'b0, AD_W'(rows_m1)});
        ad      = diff[AD_W] ? AD_W'(-diff) : AD_W'(diff);
        x2      = X_W'(i_along_step) * X_W'(ad);
        r2p     = X_W'(i_range_spacing) * X_W'({r_pcol, 1'b0});
        r2      = (r2p < X_W'(i_range_spacing)) ? X_W'(i_range_spacing) : r2p;
    end

    // ---- multiply-accumulate, top chunk first
    logic [MP_W-1:0]  mac_prod;
    logic [ACC_W-1:0] acc_next;

    always_comb begin
        mac_prod = MP_W'(r_ma) * MP_W'(r_mb[BW-1 -: CHUNK_W]);
        acc_next = (r_acc << CHUNK_W) + ACC_W'(mac_prod);
    end

    // ---- square root, one result bit per step
    logic [R_W+1:0] rem_t, trial;
    logic           ge;
    logic [R_W-1:0] rem_n;
    logic [S_W-1:0] root_n;

    always_comb begin
        rem_t  = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = (R_W+2)'({r_root, 2'b01});
        ge     = (rem_t >= trial);
        rem_n  = ge ? R_W'(rem_t - trial) : R_W'(rem_t);
        root_n = {r_root[S_W-2:0], ge};
    end

    // ---- phase word and rotator seed
    logic [P_W-1:0]          p;
    logic [PH_W-1:0]         ph;
    logic [PHASE_W-1:0]      phs;
    logic [ANGLE_W-1:0]      ang, ang2;
    logic                    pre;
    logic signed [CX_W-1:0]  xs, ys;

    always_comb begin
        p    = P_W'(r_acc) + PH_RND;
        ph   = p[P_W-1:PH_SHIFT];
        phs  = (|ph[PH_W-1:PHASE_W]) ? PHASE_MAX : ph[PHASE_W-1:0];
        ang  = {p[PH_SHIFT +: FRAC_W], {(ANGLE_W-FRAC_W){1'b0}}};
        // angles in the left half-plane get a half-turn first
        pre  = ang[ANGLE_W-1] ^ ang[ANGLE_W-2];
        ang2 = pre ? (ang ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : ang;
        xs   = $signed({{(CX_W-SAMPLE_WIDTH){r_re[SAMPLE_WIDTH-1]}}, r_re}) <<< G;
        ys   = $signed({{(CX_W-SAMPLE_WIDTH){r_im[SAMPLE_WIDTH-1]}}, r_im}) <<< G;
    end

    // ---- rotator micro-rotation
    logic [4:0]             idx;
    logic signed [CX_W-1:0] dx, dy;
    logic [Z_W-1:0]         at;

    always_comb begin
        idx = i_step[4:0];
        dx  = r_cy >>> idx;
        dy  = r_cx >>> idx;
        at  = Z_W'(atan_turn(idx));
    end

    // counters and phase tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.capture) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cmd.ph_fin) begin
                if (r_first) begin
                    r_min   <= phs;
                    r_max   <= phs;
                    r_first <= 1'b0;
                end else begin
                    if (phs < r_min) r_min <= phs;
                    if (phs > r_max) r_max <= phs;
                end
            end
            // end of image clears the tracker
            if (i_cmd.out_load && r_last) begin
                r_min   <= '0;
                r_max   <= '0;
                r_first <= 1'b1;
            end
        end
    end

    // item capture and arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_re   <= i_sample_re;
            r_im   <= i_sample_im;
            r_mode <= i_mode;
            r_rows <= rows_c;
            r_prow <= r_row;
            r_pcol <= r_col;
            r_last <= last_row && last_col;
        end
        if (i_cmd.seed) begin
            r_r2  <= r2;
            r_ma  <= S_W'(x2);
            r_mb  <= BW'(x2);
            r_acc <= '0;
        end
        // last chunk of the along-track square switches to the range square
        if (i_cmd.mac_to_r) begin
            r_sqx <= acc_next;
            r_ma  <= S_W'(r_r2);
            r_mb  <= BW'(r_r2);
            r_acc <= '0;
        end else if (i_cmd.mac_step) begin
            r_acc <= acc_next;
            r_mb  <= r_mb << CHUNK_W;
        end
        if (i_cmd.sum) begin
            r_rad  <= RAD_W'(r_sqx) + RAD_W'(r_acc);
            r_rem  <= '0;
            r_root <= '0;
            r_acc  <= '0;
            r_mb   <= BW'(i_tow);
        end
        if (i_cmd.root_step) begin
            r_rem  <= rem_n;
            r_root <= root_n;
            r_rad  <= r_rad << 2;
        end
        if (i_cmd.root_last) begin
            r_ma <= root_n;
        end
        if (i_cmd.ph_fin) begin
            r_cx <= pre ? -xs : xs;
            r_cy <= pre ? -ys : ys;
            r_cz <= $signed({{(Z_W-ANGLE_W){ang2[ANGLE_W-1]}}, ang2});
        end
        if (i_cmd.rot_step) begin
            if (!r_cz[Z_W-1]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - $signed(at);
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + $signed(at);
            end
        end
        if (i_cmd.gain) begin
            r_gx <= r_cx * GAIN_K_S;
            r_gy <= r_cy * GAIN_K_S;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_re   <= r_mode ? round_sat(r_gx) : r_re;
            r_o_im   <= r_mode ? round_sat(r_gy) : r_im;
            r_o_last <= r_last;
            r_o_app  <= r_mode;
            r_o_min  <= r_mode ? r_min : '0;
            r_o_max  <= r_mode ? r_max : '0;
        end
    end

    assign o_stat.out_free = !r_ov || !i_out_stall;
    assign o_out_valid     = r_ov;
    assign o_out_re        = r_o_re;
    assign o_out_im        = r_o_im;
    assign o_last_pixel    = r_o_last;
    assign o_applied       = r_o_app;
    assign o_min_phase     = r_o_min;
    assign o_max_phase     = r_o_max;

endmodule

/* rtl/core/sar_broadside_phase_reference.sv */
// ----------------------------------------------------------------------------
// sar_broadside_phase_reference
// In reference mode, rotates each raster-order image pixel by the fractional
// turn of its broadside slant-range phase and reports running phase min/max.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  input    | i_in_valid / o_in_stall        | i_sample_re, i_sample_im
//  output   | o_out_valid / i_out_stall      | o_out_re, o_out_im, o_last_pixel,
//           |                                | o_applied, o_min_phase, o_max_phase
//  config   | i_cfg_we                       | i_cfg_idx, i_cfg_data
//
//  Reference mode: each item walks through the bit-serial square root
//  (S_W steps) and the iterative rotator.
//  Native mode passes the samples through unrotated.
//  One item is in work at a time; the next is taken while a result waits.
//  A stalled output holds the finished item in the output register.
//  Synchronous reset; no memory to clear.
// ----------------------------------------------------------------------------
module sar_broadside_phase_reference #(
    parameter int MAX_DIM       = 4096,
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [sbpr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sbpr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]              i_sample_re,
    input  logic [SAMPLE_WIDTH-1:0]              i_sample_im,
    // result items
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]              o_out_re,
    output logic [SAMPLE_WIDTH-1:0]              o_out_im,
    output logic                                 o_last_pixel,
    output logic                                 o_applied,
    output logic [sbpr_pkg::PHASE_W-1:0]         o_min_phase,
    output logic [sbpr_pkg::PHASE_W-1:0]         o_max_phase
);
    import sbpr_pkg::*;

    localparam int CW      = $clog2(MAX_DIM);
    localparam int DW      = ($clog2(MAX_DIM + 1) > DIM_CFG_W) ? $clog2(MAX_DIM + 1)
                                                               : DIM_CFG_W;
    localparam int X_W     = DIST_W + CW + 1;
    localparam int SUM_W   = 2 * X_W + 1;
    localparam int S_W     = (SUM_W + 1) / 2;
    localparam int NX      = (X_W + CHUNK_W - 1) / CHUNK_W;
    localparam int ACC_W   = (SUM_W > S_W + TOW_W) ? SUM_W : S_W + TOW_W;
    localparam int STAGES  = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int MAXSTEP = (S_W > STAGES) ? S_W : STAGES;
    localparam int STEP_W  = $clog2(MAXSTEP);

    // configuration registers
    logic                 r_cfg_mode;
    logic [DIM_CFG_W-1:0] r_cfg_rows, r_cfg_cols;
    logic [DIST_W-1:0]    r_cfg_spacing, r_cfg_step;
    logic [TOW_W-1:0]     r_cfg_tow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode    <= 1'b0;
            r_cfg_rows    <= RST_NUM_ROWS;
            r_cfg_cols    <= RST_NUM_COLS;
            r_cfg_spacing <= RST_SPACING;
            r_cfg_step    <= RST_STEP;
            r_cfg_tow     <= RST_TOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:          r_cfg_mode    <= i_cfg_data[0];
                REG_NUM_ROWS:      r_cfg_rows    <= i_cfg_data[DIM_CFG_W-1:0];
                REG_NUM_COLS:      r_cfg_cols    <= i_cfg_data[DIM_CFG_W-1:0];
                REG_RANGE_SPACING: r_cfg_spacing <= i_cfg_data[DIST_W-1:0];
                REG_ALONG_STEP:    r_cfg_step    <= i_cfg_data[DIST_W-1:0];
                REG_TWO_OVER_WL:   r_cfg_tow     <= i_cfg_data[TOW_W-1:0];
                default: ;
            endcase
        end
    end

    t_cmd              cmd;
    t_stat             stat;
    logic [STEP_W-1:0] step;

    // sequencer
    sbpr_ctrl #(
        .NX     (NX),
        .S_W    (S_W),
        .STAGES (STAGES),
        .STEP_W (STEP_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (r_cfg_mode),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_step     (step)
    );

    // datapath
    sbpr_dp #(
        .MAX_DIM      (MAX_DIM),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW),
        .DW           (DW),
        .X_W          (X_W),
        .S_W          (S_W),
        .NX           (NX),
        .ACC_W        (ACC_W),
        .STEP_W       (STEP_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_step          (step),
        .i_mode          (r_cfg_mode),
        .i_num_rows      (r_cfg_rows),
        .i_num_cols      (r_cfg_cols),
        .i_range_spacing (r_cfg_spacing),
        .i_along_step    (r_cfg_step),
        .i_tow           (r_cfg_tow),
        .i_sample_re     (i_sample_re),
        .i_sample_im     (i_sample_im),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_re        (o_out_re),
        .o_out_im        (o_out_im),
        .o_last_pixel    (o_last_pixel),
        .o_applied       (o_applied),
        .o_min_phase     (o_min_phase),
        .o_max_phase     (o_max_phase)
    );

endmodule

/* rtl/core/sbpr_chk.sv */
// ----------------------------------------------------------------------------
// sbpr_chk
// Port-level checks for the broadside phase reference block.
// ----------------------------------------------------------------------------
`include "sar_broadside_phase_reference_assert.svh"

module sbpr_chk #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [SAMPLE_WIDTH-1:0]       o_out_re,
    input logic [SAMPLE_WIDTH-1:0]       o_out_im,
    input logic                          o_applied,
    input logic [sbpr_pkg::PHASE_W-1:0]  o_min_phase,
    input logic [sbpr_pkg::PHASE_W-1:0]  o_max_phase
);

    // a held result keeps its samples and max phase
    `SBPR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_re) && $stable(o_out_im) && $stable(o_max_phase))

    // one item at a time: busy right after an accept
    `SBPR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // native items carry no phase report
    `SBPR_ASSERT_NOW(a_native_no_phase, o_out_valid && !o_applied, o_min_phase == '0 && o_max_phase == '0)

    // tracker order
    `SBPR_ASSERT_NOW(a_min_le_max, o_out_valid && o_applied, o_min_phase <= o_max_phase)

endmodule

bind sar_broadside_phase_reference sbpr_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sbpr_chk (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Broadside phase reference testbench
// Drives raster-order complex pixels through the block under several image
// geometries and register settings. Each item is predicted in place
// (slant range, unwrapped phase, CORDIC rotation, running min/max). Results
// are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpr_pkg::*;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  ITEM_TARGET  = 1900;
    localparam int  QUIET_AFTER  = 1600;
    localparam int  SAT_HI       = 32767;
    localparam int  SAT_LO       = -32768;
    localparam longint GAIN      = 10188014;

    localparam logic [31:0] ATAN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
    } t_pixel;

    typedef struct packed {
        logic [15:0]        re;
        logic [15:0]        im;
        logic               last;
        logic               applied;
        logic [PHASE_W-1:0] min_ph;
        logic [PHASE_W-1:0] max_ph;
    } t_rotated;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [15:0]        i_sample_re;
    logic [15:0]        i_sample_im;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [15:0]        o_out_re;
    logic [15:0]        o_out_im;
    logic               o_last_pixel;
    logic               o_applied;
    logic [PHASE_W-1:0] o_min_phase;
    logic [PHASE_W-1:0] o_max_phase;

    sar_broadside_phase_reference DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_sample_re(i_sample_re), .i_sample_im(i_sample_im),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_re(o_out_re), .o_out_im(o_out_im), .o_last_pixel(o_last_pixel),
        .o_applied(o_applied), .o_min_phase(o_min_phase), .o_max_phase(o_max_phase)
    );

    // predictor copy of registers and image state
    logic        cur_mode;
    logic [12:0] cur_rows, cur_cols;
    logic [23:0] cur_spacing, cur_step;
    logic [31:0] cur_tow;
    logic [11:0] row_pos, col_pos;
    logic [PHASE_W-1:0] min_ph, max_ph;
    logic        no_phase_yet;

    t_pixel   pixel_q[$];
    t_rotated rotated_q[$];
    int       n_sent, n_accepted, n_errors, n_cycles;
    bit       quiet, long_hold;

    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("** sar_broadside_phase_reference: FAILED **");
            $finish;
        end
    end

    function automatic int clamp_dim(input logic [12:0] d);
        if (d == 0) return 1;
        if (d > 4096) return 4096;
        return int'(d);
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return v[15:0];
    endfunction

    // CORDIC rotation by frac/65536 turn with gain correction
    function automatic void cordic(input logic [15:0] re, input logic [15:0] im,
                                   input logic [15:0] frac,
                                   output logic [15:0] ore, output logic [15:0] oim);
        longint x, y, z, dx, dy;
        logic [31:0] a;
        x = longint'($signed(re)) * 2097152;
        y = longint'($signed(im)) * 2097152;
        a = {frac, 16'h0};
        // half-turn pre-rotation for angles in [1/4, 3/4)
        if (((a + 32'h40000000) & 32'h80000000) != 0) begin
            x = -x;
            y = -y;
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN[i]);
            end
        end
        ore = sat16((x * GAIN + (64'sd1 <<< 44)) >>> 45);
        oim = sat16((y * GAIN + (64'sd1 <<< 44)) >>> 45);
    endfunction

    // expected result of one pixel; advances the raster position
    function automatic t_rotated rotate_pixel(input t_pixel px);
        t_rotated r;
        int rows, cols, d2;
        bit last_row, last_col;
        logic [79:0] x2, r2, sum, c, p;
        logic [39:0] root, cand;
        logic [PHASE_W+3:0] ph;
        rows = clamp_dim(cur_rows);
        cols = clamp_dim(cur_cols);
        last_row = int'(row_pos) + 1 >= rows;
        last_col = int'(col_pos) + 1 >= cols;
        if (!cur_mode) begin
            r.re = px.re; r.im = px.im;
            r.applied = 1'b0; r.min_ph = '0; r.max_ph = '0;
        end else begin
            d2 = 2 * int'(row_pos) - (rows - 1);
            if (d2 < 0) d2 = -d2;
            x2 = 80'(cur_step) * 80'(d2);
            r2 = 80'(2) * 80'(col_pos) * 80'(cur_spacing);
            if (r2 < 80'(cur_spacing)) r2 = 80'(cur_spacing);
            sum = x2 * x2 + r2 * r2;
            root = '0;
            for (int b = 39; b >= 0; b--) begin
                cand = root | (40'd1 << b);
                c = 80'(cand);
                if (c * c <= sum) root = cand;
            end
            p = 80'(root) * 80'(cur_tow) + 80'(1 << 22);
            ph = p[PHASE_W+3+23:23];
            cordic(px.re, px.im, ph[15:0], r.re, r.im);
            if (ph > PHASE_MAX) ph = PHASE_MAX;
            if (no_phase_yet) begin
                min_ph = ph; max_ph = ph; no_phase_yet = 1'b0;
            end else begin
                if (ph < min_ph) min_ph = ph;
                if (ph > max_ph) max_ph = ph;
            end
            r.applied = 1'b1; r.min_ph = min_ph; r.max_ph = max_ph;
        end
        r.last = last_row && last_col;
        if (last_col) begin
            col_pos = '0;
            if (last_row) begin
                row_pos = '0; min_ph = '0; max_ph = '0; no_phase_yet = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // pixel driver
    int in_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rotated_q.push_back(rotate_pixel('{i_sample_re, i_sample_im}));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        in_gap = $urandom_range(1, 6) - 1;
                        i_in_valid <= 1'b0;
                    end else begin
                        t_pixel px;
                        px = pixel_q.pop_front();
                        i_sample_re <= px.re;
                        i_sample_im <= px.im;
                        i_in_valid  <= 1'b1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int out_gap;
    always @(posedge i_clk) begin
        t_rotated got, want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_re, o_out_im, o_last_pixel, o_applied,
                        o_min_phase, o_max_phase};
                if (rotated_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result item: %p", got);
                end else begin
                    want = rotated_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 6);
            end
            i_out_stall <= long_hold || (out_gap > 0);
        end
    end

    // long receiver hold so the block backs up into its input
    initial begin
        long_hold = 1'b0;
        wait (n_accepted >= 300);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_MODE:          cur_mode    = val[0];
            REG_NUM_ROWS:      cur_rows    = val[12:0];
            REG_NUM_COLS:      cur_cols    = val[12:0];
            REG_RANGE_SPACING: cur_spacing = val[23:0];
            REG_ALONG_STEP:    cur_step    = val[23:0];
            REG_TWO_OVER_WL:   cur_tow     = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic m, input logic [12:0] rows,
                                input logic [12:0] cols, input logic [23:0] sp,
                                input logic [23:0] st, input logic [31:0] tw);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_NUM_ROWS, 32'(rows));
        write_reg(REG_NUM_COLS, 32'(cols));
        write_reg(REG_RANGE_SPACING, 32'(sp));
        write_reg(REG_ALONG_STEP, 32'(st));
        write_reg(REG_TWO_OVER_WL, tw);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || rotated_q.size() != 0);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_pixels(input int n);
        for (int k = 0; k < n; k++) begin
            pixel_q.push_back('{pick_sample(), pick_sample()});
            n_sent++;
        end
    endtask

    function automatic logic [23:0] pick_dist();
        case ($urandom_range(0, 5))
            0: return 24'd1;
            1: return 24'hFFFFFF;
            default: return 24'($urandom_range(1, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [31:0] pick_tow();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFFFFFF;
            default: return $urandom_range(1, 32'hFFFFFFFF);
        endcase
    endfunction

    // ------------------------------------------------------------------
    initial begin
        int rows, cols, n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_sample_re = '0; i_sample_im = '0;
        i_out_stall = 1'b0;
        n_cycles = 0; n_sent = 0; n_accepted = 0; n_errors = 0; quiet = 1'b0;
        cur_mode = 1'b0; cur_rows = RST_NUM_ROWS; cur_cols = RST_NUM_COLS;
        cur_spacing = RST_SPACING; cur_step = RST_STEP; cur_tow = RST_TOW;
        row_pos = '0; col_pos = '0; min_ph = '0; max_ph = '0; no_phase_yet = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: native passthrough, 1x1 image
        pixel_q.push_back('{16'h7FFF, 16'h8000});
        pixel_q.push_back('{16'h8000, 16'h7FFF});
        n_sent += 2;
        wait_drained();

        // reference mode, small image with extreme samples
        set_geometry(1'b1, 13'd3, 13'd4, RST_SPACING, RST_STEP, RST_TOW);
        pixel_q.push_back('{16'h7FFF, 16'h7FFF});
        pixel_q.push_back('{16'h8000, 16'h8000});
        pixel_q.push_back('{16'h0000, 16'h0000});
        pixel_q.push_back('{16'hFFFF, 16'h0001});
        n_sent += 4;
        queue_pixels(8);
        wait_drained();

        // zero and oversize dimensions, extreme distances, partial image
        set_geometry(1'b1, 13'd0, 13'h1FFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_pixels(3);
        wait_drained();
        // shrink mid-image: column counter is beyond the new limit
        set_geometry(1'b1, 13'd5000, 13'd2, 24'd1, 24'd1, 32'd1);
        queue_pixels(4);
        wait_drained();
        set_geometry(1'b0, 13'd1, 13'd2, 24'd1, 24'd1, 32'd1);
        queue_pixels(3);
        wait_drained();

        // random geometries, mostly whole small images
        while (n_sent < ITEM_TARGET) begin
            rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 5);
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 6);
            set_geometry(($urandom_range(0, 5) != 0), 13'(rows), 13'(cols),
                         pick_dist(), pick_dist(), pick_tow());
            n = clamp_dim(13'(rows)) * clamp_dim(13'(cols));
            if (n > 40 || $urandom_range(0, 5) == 0)
                n = $urandom_range(1, 30);
            if (n_sent > QUIET_AFTER) quiet = 1'b1;
            queue_pixels(n);
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && rotated_q.size() == 0)
            $display("** sar_broadside_phase_reference: PASSED **");
        else
            $display("** sar_broadside_phase_reference: FAILED **");
        $finish;
    end

endmodule
